>>> rtl/strip_coverage_area_tracker_top_assert.svh
// Assertion macros for the strip coverage area tracker.
`ifndef STRIP_COVERAGE_AREA_TRACKER_TOP_ASSERT_SVH
`define STRIP_COVERAGE_AREA_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SCAT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SCAT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/scat_pkg.sv
// Shared types and constants of the strip coverage area tracker.
package scat_pkg;

	localparam int COORD_W = 24;
	localparam int COLOR_W = 24;
	localparam int STEP_W = 52;
	localparam int AREA_W = 63;
	localparam int CFG_IDX_W = 2;
	localparam int SPLIT_LIMIT_DEF = 61;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [COORD_W-1:0] BOX_TOP = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] BOX_BOT = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_ADD = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MULTI_COLOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_COLOR = 2'd2;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_START,
		CMD_ADD,
		CMD_STOP
	} cmd_t;

	typedef enum logic [2:0] {
		EVT_NONE = 3'd0,
		EVT_OPEN = 3'd1,
		EVT_SPLIT = 3'd2,
		EVT_KEPT = 3'd3,
		EVT_DISCARD = 3'd4
	} evt_t;

	typedef struct packed {
		cmd_t cmd;
		logic signed [COORD_W-1:0] le;
		logic signed [COORD_W-1:0] ln;
		logic signed [COORD_W-1:0] re;
		logic signed [COORD_W-1:0] rn;
		logic [COLOR_W-1:0] color;
	} item_t;

endpackage

>>> rtl/scat_queue.sv
// Two-entry word queue between the classifier and the execution pipeline.
module scat_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  scat_pkg::item_t      push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output scat_pkg::item_t      pop_item
);

	scat_pkg::item_t mem [scat_pkg::QUEUE_DEPTH];
	logic [scat_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [scat_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [scat_pkg::QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != scat_pkg::QCNT_W'(scat_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/scat_front.sv
// Front end: configuration registers and event classification.
module scat_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [scat_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [scat_pkg::COLOR_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            kind,
	input  logic signed [scat_pkg::COORD_W-1:0]   left_east,
	input  logic signed [scat_pkg::COORD_W-1:0]   left_north,
	input  logic signed [scat_pkg::COORD_W-1:0]   right_east,
	input  logic signed [scat_pkg::COORD_W-1:0]   right_north,
	input  logic [scat_pkg::COLOR_W-1:0]          sect_color,
	output logic                                  push_valid,
	input  logic                                  push_ready,
	output scat_pkg::item_t                       push_item
);

	logic multi_color_q;
	logic sections_q;
	logic [scat_pkg::COLOR_W-1:0] day_color_q;

	assign cfg_ready = 1'b1;
	assign push_valid = in_valid;
	assign in_ready = push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_color_q <= 1'b0;
			sections_q <= 1'b1;
			day_color_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scat_pkg::CFG_MULTI_COLOR: multi_color_q <= cfg_data[0];
				scat_pkg::CFG_SECTIONS: sections_q <= cfg_data[0];
				scat_pkg::CFG_DAY_COLOR: day_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Resolve the patch color now; the user must keep config static while items are in flight (not enforced).
	always_comb begin
		push_item.le = left_east;
		push_item.ln = left_north;
		push_item.re = right_east;
		push_item.rn = right_north;
		push_item.cmd = scat_pkg::CMD_NONE;
		push_item.color = '0;
		case (kind)
			scat_pkg::KIND_START: begin
				push_item.cmd = scat_pkg::CMD_START;
				push_item.color = (multi_color_q && sections_q) ? sect_color : day_color_q;
			end
			scat_pkg::KIND_ADD: begin
				push_item.cmd = scat_pkg::CMD_ADD;
				push_item.color = multi_color_q ? sect_color : day_color_q;
			end
			scat_pkg::KIND_STOP: begin
				push_item.cmd = scat_pkg::CMD_STOP;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/scat_back.sv
// Back end: strip state, shoelace area pipeline and output register.
module scat_back #(
	parameter int SPLIT_LIMIT = scat_pkg::SPLIT_LIMIT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	output logic                                  q_ready,
	input  scat_pkg::item_t                       q_item,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [scat_pkg::STEP_W-1:0]           area_step,
	output logic [scat_pkg::AREA_W-1:0]           area_total,
	output logic [2:0]                            patch_event,
	output logic [scat_pkg::COLOR_W-1:0]          patch_color,
	output logic signed [scat_pkg::COORD_W-1:0]   box_min_east,
	output logic signed [scat_pkg::COORD_W-1:0]   box_max_east,
	output logic signed [scat_pkg::COORD_W-1:0]   box_min_north,
	output logic signed [scat_pkg::COORD_W-1:0]   box_max_north
);

	localparam int CW = scat_pkg::COORD_W;
	localparam int CNT_W = $clog2(SPLIT_LIMIT + 1);
	localparam int DIFF_W = CW + 1;
	localparam int PROD_W = CW + DIFF_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int T_W = SUM_W + 1;

	// state
	logic drawing_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [CW-1:0] prev_q [4];
	logic signed [CW-1:0] box_q [4];

	// next state and stage 0 results
	logic drawing_d;
	logic [CNT_W-1:0] cnt_d;
	logic signed [CW-1:0] box_d [4];
	logic signed [CW-1:0] nb [4];
	logic signed [CW-1:0] box_o [4];
	logic load_prev;
	logic is_add;
	scat_pkg::evt_t evt;
	logic [scat_pkg::COLOR_W-1:0] color;
	logic split;
	logic signed [DIFF_W-1:0] d_a, d_b, d_c, d_d, d_e;
	logic signed [PROD_W-1:0] prod [6];

	// pipeline
	logic en1, en2, en3, pop;
	logic v1_q, v2_q, v3_q;
	logic is_add_s1;
	logic signed [PROD_W-1:0] prod_s1 [6];
	scat_pkg::evt_t evt_s1, evt_s2, evt_s3;
	logic [scat_pkg::COLOR_W-1:0] color_s1, color_s2, color_s3;
	logic signed [CW-1:0] box_s1 [4];
	logic signed [CW-1:0] box_s2 [4];
	logic signed [CW-1:0] box_s3 [4];
	logic [scat_pkg::STEP_W-1:0] step_s2, step_s3;
	logic [scat_pkg::AREA_W-1:0] area_q;
	logic signed [SUM_W-1:0] sum_a, sum_b;
	logic [SUM_W-1:0] abs_a, abs_b;
	logic [T_W-1:0] tri_sum;
	logic [scat_pkg::AREA_W:0] area_add;

	assign en3 = !v3_q || out_ready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign q_ready = en1;
	assign pop = q_valid && en1;

	// Stage 0: box growth and shoelace differences against the previous pair.
	always_comb begin
		nb[0] = (q_item.le < box_q[0]) ? q_item.le : box_q[0];
		nb[1] = (q_item.le > box_q[1]) ? q_item.le : box_q[1];
		nb[2] = (q_item.ln < box_q[2]) ? q_item.ln : box_q[2];
		nb[3] = (q_item.ln > box_q[3]) ? q_item.ln : box_q[3];
		if (q_item.re < nb[0]) nb[0] = q_item.re;
		if (q_item.re > nb[1]) nb[1] = q_item.re;
		if (q_item.rn < nb[2]) nb[2] = q_item.rn;
		if (q_item.rn > nb[3]) nb[3] = q_item.rn;
	end

	always_comb begin
		d_a = DIFF_W'(q_item.ln) - DIFF_W'(prev_q[3]);
		d_b = DIFF_W'(prev_q[3]) - DIFF_W'(q_item.rn);
		d_c = DIFF_W'(q_item.rn) - DIFF_W'(q_item.ln);
		d_d = DIFF_W'(prev_q[3]) - DIFF_W'(prev_q[1]);
		d_e = DIFF_W'(prev_q[1]) - DIFF_W'(q_item.ln);
		prod[0] = PROD_W'(q_item.re) * PROD_W'(d_a);
		prod[1] = PROD_W'(q_item.le) * PROD_W'(d_b);
		prod[2] = PROD_W'(prev_q[2]) * PROD_W'(d_c);
		prod[3] = PROD_W'(q_item.le) * PROD_W'(d_d);
		prod[4] = PROD_W'(prev_q[2]) * PROD_W'(d_e);
		prod[5] = PROD_W'(prev_q[0]) * PROD_W'(d_a);
	end

	always_comb begin
		drawing_d = drawing_q;
		cnt_d = cnt_q;
		load_prev = 1'b0;
		is_add = 1'b0;
		evt = scat_pkg::EVT_NONE;
		color = '0;
		split = (cnt_q == CNT_W'(SPLIT_LIMIT));
		for (int i = 0; i < 4; i++) begin
			box_d[i] = box_q[i];
			box_o[i] = '0;
		end
		case (q_item.cmd)
			scat_pkg::CMD_START: begin
				cnt_d = '0;
				if (!drawing_q) begin
					drawing_d = 1'b1;
					load_prev = 1'b1;
					evt = scat_pkg::EVT_OPEN;
					color = q_item.color;
					box_d[0] = scat_pkg::BOX_TOP;
					box_d[1] = scat_pkg::BOX_BOT;
					box_d[2] = scat_pkg::BOX_TOP;
					box_d[3] = scat_pkg::BOX_BOT;
				end
			end
			scat_pkg::CMD_ADD, scat_pkg::CMD_STOP: begin
				if (drawing_q) begin
					is_add = 1'b1;
					load_prev = 1'b1;
					cnt_d = cnt_q + 1'b1;
					for (int i = 0; i < 4; i++) begin
						box_d[i] = nb[i];
					end
					if (split) begin
						cnt_d = '0;
						box_d[0] = scat_pkg::BOX_TOP;
						box_d[1] = scat_pkg::BOX_BOT;
						box_d[2] = scat_pkg::BOX_TOP;
						box_d[3] = scat_pkg::BOX_BOT;
					end
					if (q_item.cmd == scat_pkg::CMD_ADD) begin
						if (split) begin
							evt = scat_pkg::EVT_SPLIT;
							color = q_item.color;
							for (int i = 0; i < 4; i++) begin
								box_o[i] = nb[i];
							end
						end
					end else begin
						drawing_d = 1'b0;
						cnt_d = '0;
						evt = split ? scat_pkg::EVT_DISCARD : scat_pkg::EVT_KEPT;
						for (int i = 0; i < 4; i++) begin
							box_o[i] = nb[i];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drawing_q <= 1'b0;
			cnt_q <= '0;
			box_q[0] <= scat_pkg::BOX_TOP;
			box_q[1] <= scat_pkg::BOX_BOT;
			box_q[2] <= scat_pkg::BOX_TOP;
			box_q[3] <= scat_pkg::BOX_BOT;
		end else if (pop) begin
			drawing_q <= drawing_d;
			cnt_q <= cnt_d;
			for (int i = 0; i < 4; i++) begin
				box_q[i] <= box_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && load_prev) begin
			prev_q[0] <= q_item.le;
			prev_q[1] <= q_item.ln;
			prev_q[2] <= q_item.re;
			prev_q[3] <= q_item.rn;
		end
	end

	// Stage 1: products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) v1_q <= pop;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			is_add_s1 <= is_add;
			evt_s1 <= evt;
			color_s1 <= color;
			for (int i = 0; i < 6; i++) begin
				prod_s1[i] <= prod[i];
			end
			for (int i = 0; i < 4; i++) begin
				box_s1[i] <= box_o[i];
			end
		end
	end

	// Stage 2: twice the triangle areas, absolute, halved.
	always_comb begin
		sum_a = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2]);
		sum_b = SUM_W'(prod_s1[3]) + SUM_W'(prod_s1[4]) + SUM_W'(prod_s1[5]);
		abs_a = sum_a[SUM_W-1] ? SUM_W'(-sum_a) : SUM_W'(sum_a);
		abs_b = sum_b[SUM_W-1] ? SUM_W'(-sum_b) : SUM_W'(sum_b);
		tri_sum = T_W'(abs_a) + T_W'(abs_b);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			step_s2 <= is_add_s1 ? scat_pkg::STEP_W'(tri_sum >> 1) : '0;
			evt_s2 <= evt_s1;
			color_s2 <= color_s1;
			for (int i = 0; i < 4; i++) begin
				box_s2[i] <= box_s1[i];
			end
		end
	end

	// Stage 3: saturating total and output register.
	assign area_add = {1'b0, area_q} + (scat_pkg::AREA_W + 1)'(step_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
		end else if (en3 && v2_q) begin
			area_q <= area_add[scat_pkg::AREA_W] ? {scat_pkg::AREA_W{1'b1}}
				: area_add[scat_pkg::AREA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			step_s3 <= step_s2;
			evt_s3 <= evt_s2;
			color_s3 <= color_s2;
			for (int i = 0; i < 4; i++) begin
				box_s3[i] <= box_s2[i];
			end
		end
	end

	assign out_valid = v3_q;
	assign area_step = step_s3;
	assign area_total = area_q;
	assign patch_event = evt_s3;
	assign patch_color = color_s3;
	assign box_min_east = box_s3[0];
	assign box_max_east = box_s3[1];
	assign box_min_north = box_s3[2];
	assign box_max_north = box_s3[3];

endmodule

>>> rtl/strip_coverage_area_tracker_top.sv
// Top level of the strip coverage area tracker.
//
// channel  direction  handshake              word
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    kind, edge points, sect_color
// out      out        out_valid / out_ready  area and patch fields
//
// One event per cycle sustained while out_ready stays high; each result passes the
// queue, the product stage, the area stage and the output register.
// A two-word queue parts intake from the pipeline; each stalls on its own.
// Reset clears strip state, the patch box to empty and the area total to zero.
// cfg_ready is always high.
`include "strip_coverage_area_tracker_top_assert.svh"

module strip_coverage_area_tracker_top #(
	parameter int SPLIT_LIMIT = scat_pkg::SPLIT_LIMIT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [scat_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [scat_pkg::COLOR_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            kind,
	input  logic signed [scat_pkg::COORD_W-1:0]   left_east,
	input  logic signed [scat_pkg::COORD_W-1:0]   left_north,
	input  logic signed [scat_pkg::COORD_W-1:0]   right_east,
	input  logic signed [scat_pkg::COORD_W-1:0]   right_north,
	input  logic [scat_pkg::COLOR_W-1:0]          sect_color,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [scat_pkg::STEP_W-1:0]           area_step,
	output logic [scat_pkg::AREA_W-1:0]           area_total,
	output logic [2:0]                            patch_event,
	output logic [scat_pkg::COLOR_W-1:0]          patch_color,
	output logic signed [scat_pkg::COORD_W-1:0]   box_min_east,
	output logic signed [scat_pkg::COORD_W-1:0]   box_max_east,
	output logic signed [scat_pkg::COORD_W-1:0]   box_min_north,
	output logic signed [scat_pkg::COORD_W-1:0]   box_max_north
);

	logic push_valid;
	logic push_ready;
	scat_pkg::item_t push_item;
	logic q_valid;
	logic q_ready;
	scat_pkg::item_t q_item;

	scat_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.left_east     (left_east),
		.left_north    (left_north),
		.right_east    (right_east),
		.right_north   (right_north),
		.sect_color    (sect_color),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	scat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	scat_back #(
		.SPLIT_LIMIT (SPLIT_LIMIT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.area_step     (area_step),
		.area_total    (area_total),
		.patch_event   (patch_event),
		.patch_color   (patch_color),
		.box_min_east  (box_min_east),
		.box_max_east  (box_max_east),
		.box_min_north (box_min_north),
		.box_max_north (box_max_north)
	);

	`SCAT_ASSERT_NOW(a_color_only_on_open, clk, arst_n, out_valid && patch_event != scat_pkg::EVT_OPEN && patch_event != scat_pkg::EVT_SPLIT, patch_color == '0, "patch color set on an event that opens no patch")
	`SCAT_ASSERT_NOW(a_box_only_on_save, clk, arst_n, out_valid && (patch_event == scat_pkg::EVT_NONE || patch_event == scat_pkg::EVT_OPEN), box_min_east == '0 && box_max_east == '0 && box_min_north == '0 && box_max_north == '0, "box reported on an event that saves no patch")
	`SCAT_ASSERT_NOW(a_open_adds_no_area, clk, arst_n, out_valid && patch_event == scat_pkg::EVT_OPEN, area_step == '0, "area added by a start event")
	`SCAT_ASSERT_NEXT(a_area_monotonic, clk, arst_n, out_valid && out_ready, area_total >= $past(area_total), "area total decreased")

endmodule
